>>> design/ccsoc_pkg.sv
// Shared types, constants and codes for the coulomb-counting SOC estimator.
`default_nettype none
package ccsoc_pkg;

    localparam int CHARGE_BITS_DEF = 48;

    // Capacity in mA*ms: 16-bit mAh times 3600000 fits in 38 bits
    localparam int CAP_BITS = 38;
    localparam int MS_BITS  = 22;
    localparam logic [MS_BITS-1:0] MS_PER_HOUR = 22'd3600000;

    localparam int Q_BITS   = 16;
    localparam int SOC_BITS = 17;
    localparam logic [SOC_BITS-1:0] SOC_ONE = 17'd65536;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD      = 2'd2;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RESET  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_FIN
    } ccsoc_state_t;

    typedef struct packed {
        logic start;
    } ccsoc_div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ccsoc_div_stat_t;

endpackage
`default_nettype wire

>>> design/ccsoc_if.sv
// Valid/ready channel interfaces: sample input, result output, config write.
`default_nettype none
interface ccsoc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] current_ma;
    logic        [15:0] voltage_mv;
    logic signed [15:0] dt_ms;

    modport source (output valid, output op, output current_ma, output voltage_mv,
                    output dt_ms, input ready);
    modport sink   (input valid, input op, input current_ma, input voltage_mv,
                    input dt_ms, output ready);
endinterface

interface ccsoc_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] soc_q16;
    logic        full_reset;

    modport source (output valid, output soc_q16, output full_reset, input ready);
    modport sink   (input valid, input soc_q16, input full_reset, output ready);
endinterface

interface ccsoc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/coulomb_counter_soc_cv_reset.sv
// Top level of the coulomb-counting state-of-charge estimator.
`default_nettype none
// Coulomb-counting state-of-charge estimator. Each accepted sample adds
// current_ma * dt_ms (negative steps count as zero) into a saturating signed
// charge accumulator in mA*ms, unless the constant-voltage timer (sum of steps
// while voltage_mv is at or above cv_threshold_mv, cleared below it, saturating
// at 2^32-1) has reached cv_hold_ms, in which case the charge is cleared and
// full_reset is set. One result follows every item: soc_q16 = floor(65536 *
// (C + charge) / C) with C = capacity_mah * 3600000, clamped to 0..65536.
// A reset item (op = 1) clears charge and timer and returns 65536 through
// ST_FIN to the output register. A sample passes ST_MUL, ST_ACC, ST_CHECK and
// ST_FIN when the charge is non-negative or at or beyond a full deficit, and
// also ST_DIV when the SOC lies strictly between 0 and 1: there the restoring
// divider delivers one quotient bit per cycle, 16 bits in all. The sample port is
// ready only while the sequencer is idle; the result sits in an output
// register, so the next sample is taken while it still waits downstream.
// Config writes are always accepted; write them only while the block is idle.
module coulomb_counter_soc_cv_reset
    import ccsoc_pkg::*;
#(
    parameter int CHARGE_BITS = CHARGE_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ccsoc_in_if.sink   sample,
    ccsoc_out_if.source result,
    ccsoc_cfg_if.sink  cfg
);

    localparam int CB = CHARGE_BITS;
    localparam logic signed [CB-1:0] CHARGE_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] CHARGE_MIN = {1'b1, {(CB-1){1'b0}}};

    // Configuration registers
    logic [15:0] capacity_reg;
    logic [15:0] threshold_reg;
    logic [31:0] hold_reg;

    // Sequencer and estimator state
    ccsoc_state_t         state_reg, state_next;
    logic signed [CB-1:0] charge_reg, charge_next;
    logic [31:0]          cv_reg, cv_next;

    // Working registers for one sample
    logic signed [15:0]   cur_reg, cur_next;
    logic [15:0]          volt_reg, volt_next;
    logic [14:0]          dt_reg, dt_next;
    logic signed [31:0]   delta_reg, delta_next;
    logic [CAP_BITS-1:0]  cap_reg, cap_next;
    logic                 full_reg, full_next;
    logic [SOC_BITS-1:0]  soc_reg, soc_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [SOC_BITS-1:0]  out_soc_reg, out_soc_next;
    logic                 out_full_reg, out_full_next;

    // Divider hookup
    ccsoc_div_ctl_t       div_ctl;
    ccsoc_div_stat_t      div_stat;
    logic [CAP_BITS-1:0]  div_rem_init;
    logic [Q_BITS-1:0]    div_quo;

    logic                 in_fire;
    logic [32:0]          cv_sum;
    logic signed [CB:0]   charge_sum;
    logic [CB:0]          deficit;

    assign in_fire      = sample.valid && sample.ready;
    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign cv_sum     = {1'b0, cv_reg} + {18'b0, dt_reg};
    assign charge_sum = {charge_reg[CB-1], charge_reg}
                      + {{(CB+1-32){delta_reg[31]}}, delta_reg};
    // Deficit as a positive magnitude; one extra bit covers the minimum charge
    assign deficit    = {(CB+1){1'b0}} - {charge_reg[CB-1], charge_reg};

    always_comb
    begin
        state_next     = state_reg;
        charge_next    = charge_reg;
        cv_next        = cv_reg;
        cur_next       = cur_reg;
        volt_next      = volt_reg;
        dt_next        = dt_reg;
        delta_next     = delta_reg;
        cap_next       = cap_reg;
        full_next      = full_reg;
        soc_next       = soc_reg;
        out_valid_next = out_valid_reg;
        out_soc_next   = out_soc_reg;
        out_full_next  = out_full_reg;
        div_ctl.start  = 1'b0;
        div_rem_init   = '0;

        // Drop the result once the sink takes it
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (sample.op == OP_RESET)
                    begin
                        charge_next = '0;
                        cv_next     = '0;
                        soc_next    = SOC_ONE;
                        full_next   = 1'b0;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        cur_next   = sample.current_ma;
                        volt_next  = sample.voltage_mv;
                        // Clamp a negative step to zero
                        dt_next    = sample.dt_ms[15] ? 15'd0 : sample.dt_ms[14:0];
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                delta_next = 32'(cur_reg) * 32'($signed({1'b0, dt_reg}));
                cap_next   = {{(CAP_BITS-16){1'b0}}, capacity_reg}
                           * {{(CAP_BITS-MS_BITS){1'b0}}, MS_PER_HOUR};
                if (volt_reg >= threshold_reg)
                begin
                    cv_next = cv_sum[32] ? 32'hFFFF_FFFF : cv_sum[31:0];
                end
                else
                begin
                    cv_next = '0;
                end
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (cv_reg >= hold_reg)
                begin
                    charge_next = '0;
                    full_next   = 1'b1;
                end
                else
                begin
                    full_next = 1'b0;
                    if (charge_sum[CB] != charge_sum[CB-1])
                    begin
                        charge_next = charge_sum[CB] ? CHARGE_MIN : CHARGE_MAX;
                    end
                    else
                    begin
                        charge_next = charge_sum[CB-1:0];
                    end
                end
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!charge_reg[CB-1])
                begin
                    soc_next   = SOC_ONE;
                    state_next = ST_FIN;
                end
                else if (deficit >= {{(CB+1-CAP_BITS){1'b0}}, cap_reg})
                begin
                    soc_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_ctl.start = 1'b1;
                    div_rem_init  = cap_reg - deficit[CAP_BITS-1:0];
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    soc_next   = {1'b0, div_quo};
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_soc_next   = soc_reg;
                    out_full_next  = full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    ccsoc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .rem_init (div_rem_init),
        .divisor  (cap_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            charge_reg    <= '0;
            cv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            charge_reg    <= charge_next;
            cv_reg        <= cv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        volt_reg     <= volt_next;
        dt_reg       <= dt_next;
        delta_reg    <= delta_next;
        cap_reg      <= cap_next;
        full_reg     <= full_next;
        soc_reg      <= soc_next;
        out_soc_reg  <= out_soc_next;
        out_full_reg <= out_full_next;
    end

    // Config write transactions; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 16'd1800;
            threshold_reg <= 16'd3630;
            hold_reg      <= 32'd300000;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_CAPACITY:  capacity_reg  <= cfg.data[15:0];
                CFG_THRESHOLD: threshold_reg <= cfg.data[15:0];
                CFG_HOLD:      hold_reg      <= cfg.data;
                default:       ;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.soc_q16    = out_soc_reg;
    assign result.full_reset = out_full_reg;

endmodule
`default_nettype wire

>>> design/ccsoc_div.sv
// Restoring divider: one quotient bit per cycle of (rem << Q_BITS) / divisor.
`default_nettype none
module ccsoc_div
    import ccsoc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ccsoc_div_ctl_t       ctl,
    input  wire logic [CAP_BITS-1:0]  rem_init,
    input  wire logic [CAP_BITS-1:0]  divisor,
    output      ccsoc_div_stat_t      stat,
    output      logic [Q_BITS-1:0]    quotient
);

    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    logic [CAP_BITS-1:0] rem_reg, rem_next;
    logic [CAP_BITS-1:0] div_reg, div_next;
    logic [Q_BITS-1:0]   quo_reg, quo_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [CAP_BITS:0]   rem2;
    logic                ge;

    // Shared compare/subtract step
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, div_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next  = rem_init;
            div_next  = divisor;
            quo_next  = '0;
            cnt_next  = CNT_BITS'(Q_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Remainder stays below the divisor, so the top bit drops safely
            rem_next = ge ? CAP_BITS'(rem2 - {1'b0, div_reg}) : rem2[CAP_BITS-1:0];
            quo_next = {quo_reg[Q_BITS-2:0], ge};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule
`default_nettype wire

>>> design/ccsoc_chk.sv
// Port-level checker for the SOC estimator and its bind to the top level.
`default_nettype none
module ccsoc_chk
    import ccsoc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [SOC_BITS-1:0] soc_q16,
    input wire logic                full_reset
);

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (soc_q16 <= SOC_ONE))
        else $error("soc_q16 above one");

    a_full_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_reset) |-> (soc_q16 == SOC_ONE))
        else $error("full reset result is not full charge");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample taken while previous one still in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(soc_q16) && $stable(full_reset)))
        else $error("stalled result changed");

endmodule

bind coulomb_counter_soc_cv_reset ccsoc_chk u_ccsoc_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .soc_q16    (result.soc_q16),
    .full_reset (result.full_reset)
);
`default_nettype wire
